@@ rtl/dhot_pkg.sv @@
// Shared types and constants for the double-hashing hash table.
package dhot_pkg;

  localparam int KEY_W  = 32;
  localparam int CFG_W  = 7;
  localparam int SLOT_W = 6;
  // Width of modulus, remainders and probe arithmetic (m never exceeds 127).
  localparam int MOD_W  = 8;

  localparam logic [CFG_W-1:0] SLOTS_RESET = 7'd64;
  localparam logic [MOD_W-1:0] MOD_MIN     = 8'd2;

  // Remainder unit retires this many dividend bits per cycle.
  localparam int DIV_RADIX = 4;
  localparam int DIV_STEPS = KEY_W / DIV_RADIX;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_NEVER = 2'd0,
    ST_USED  = 2'd1,
    ST_GONE  = 2'd2
  } slot_state_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SETUP,
    S_READ,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic load;      // capture item, start remainder unit
    logic setup;     // form first probe and step
    logic rd;        // read slot at probe index
    logic adv;       // move to next probe
    logic wr;        // write slot at probe index
    logic fin_ok;    // deliver success with probe index
    logic fin_fail;  // deliver failure
  } cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       free;     // slot not occupied
    logic       never;    // slot never used
    logic       match;    // slot occupied with the item's key
    logic       last;     // this probe is the m-th
    logic [1:0] op;
  } stat_t;

endpackage

@@ rtl/dhot_div.sv @@
// Radix-16 restoring remainder unit: |key| mod m and |key| mod (m-1) together.
module dhot_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [dhot_pkg::KEY_W-1:0] dividend,
  input  logic [dhot_pkg::MOD_W-1:0] div_a,
  input  logic [dhot_pkg::MOD_W-1:0] div_b,
  output logic [dhot_pkg::MOD_W-1:0] rem_a,
  output logic [dhot_pkg::MOD_W-1:0] rem_b,
  output logic                       done
);

  localparam int KW = dhot_pkg::KEY_W;
  localparam int MW = dhot_pkg::MOD_W;
  localparam int RX = dhot_pkg::DIV_RADIX;
  localparam int CW = $clog2(dhot_pkg::DIV_STEPS);
  localparam logic [CW-1:0] LAST_STEP = CW'(dhot_pkg::DIV_STEPS - 1);

  logic [KW-1:0] shreg;
  logic [CW-1:0] cnt;
  logic          running;
  logic [MW-1:0] rem_a_next, rem_b_next;

  // Partial remainder stays below the divisor (at most 127), so the top bit is free.
  function automatic logic [MW-1:0] rem_step(input logic [MW-1:0] r, input logic b,
                                             input logic [MW-1:0] d);
    logic [MW-1:0] t;
    t = {r[MW-2:0], b};
    return (t >= d) ? t - d : t;
  endfunction

  always_comb begin
    rem_a_next = rem_a;
    rem_b_next = rem_b;
    for (int i = 0; i < RX; i++) begin
      rem_a_next = rem_step(rem_a_next, shreg[KW-1-i], div_a);
      rem_b_next = rem_step(rem_b_next, shreg[KW-1-i], div_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CW'(1);
        if (cnt == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      shreg <= dividend;
      rem_a <= '0;
      rem_b <= '0;
    end else if (running) begin
      shreg <= shreg << RX;
      rem_a <= rem_a_next;
      rem_b <= rem_b_next;
    end
  end

endmodule

@@ rtl/dhot_ctrl.sv @@
// Sequencer for the hash table: hashing, probe loop and result hand-off.
module dhot_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  dhot_pkg::stat_t  stat,
  output dhot_pkg::cmd_t   cmd,
  output logic             busy
);

  dhot_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dhot_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = (state != dhot_pkg::S_IDLE);
    case (state)
      dhot_pkg::S_IDLE: begin
        cmd.load = start;
      end
      dhot_pkg::S_SETUP: begin
        cmd.setup = 1'b1;
      end
      dhot_pkg::S_READ: begin
        cmd.rd = 1'b1;
      end
      dhot_pkg::S_CHECK: begin
        case (stat.op)
          dhot_pkg::OP_INSERT: begin
            if (stat.free) begin
              cmd.wr     = 1'b1;
              cmd.fin_ok = 1'b1;
            end else if (stat.last) begin
              cmd.fin_fail = 1'b1;
            end else begin
              cmd.adv = 1'b1;
            end
          end
          dhot_pkg::OP_SEARCH, dhot_pkg::OP_REMOVE: begin
            if (stat.never) begin
              cmd.fin_fail = 1'b1;
            end else if (stat.match) begin
              cmd.wr     = (stat.op == dhot_pkg::OP_REMOVE);
              cmd.fin_ok = 1'b1;
            end else if (stat.last) begin
              cmd.fin_fail = 1'b1;
            end else begin
              cmd.adv = 1'b1;
            end
          end
          default: begin
            cmd.fin_fail = 1'b1;
          end
        endcase
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dhot_pkg::S_IDLE: begin
        if (start) state_next = dhot_pkg::S_DIV;
      end
      dhot_pkg::S_DIV: begin
        if (stat.div_done) state_next = dhot_pkg::S_SETUP;
      end
      dhot_pkg::S_SETUP: begin
        state_next = dhot_pkg::S_READ;
      end
      dhot_pkg::S_READ: begin
        state_next = dhot_pkg::S_CHECK;
      end
      dhot_pkg::S_CHECK: begin
        state_next = cmd.adv ? dhot_pkg::S_READ : dhot_pkg::S_IDLE;
      end
      default: begin
        state_next = dhot_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.setup, cmd.rd, cmd.adv, cmd.fin_ok, cmd.fin_fail}))
    else $error("more than one datapath command at once");
  a_wr_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> cmd.fin_ok)
    else $error("slot write without a successful finish");
  a_div_to_setup: assert property (@(posedge clk) disable iff (rst)
    (state == dhot_pkg::S_DIV && stat.div_done) |=> cmd.setup)
    else $error("hash remainders ready but setup not issued");
`endif

endmodule

@@ rtl/dhot_datapath.sv @@
// Datapath: item registers, hash setup, probe index, slot stores, result register.
module dhot_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dhot_pkg::cmd_t              cmd,
  output dhot_pkg::stat_t             stat,
  input  logic [1:0]                  op,
  input  logic signed [dhot_pkg::KEY_W-1:0] key,
  input  logic                        cfg_wr,
  input  logic [dhot_pkg::CFG_W-1:0]  cfg_data,
  output logic                        done,
  output logic [dhot_pkg::SLOT_W-1:0] slot,
  output logic                        ok
);

  localparam int KW = dhot_pkg::KEY_W;
  localparam int MW = dhot_pkg::MOD_W;
  localparam int SW = dhot_pkg::SLOT_W;
  // The 7-bit modulus never reaches past index 126, so deeper stores are never touched.
  localparam int DEPTH = (CAPACITY < 128) ? CAPACITY : 128;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);

  logic [dhot_pkg::CFG_W-1:0] slots_in_use;
  logic [MW-1:0]              m_r, m_next;
  logic [1:0]                 op_r;
  logic [KW-1:0]              key_r;
  logic                       neg;
  logic [KW-1:0]              mag;
  logic [IDX_W-1:0]           j, j_next, s;
  logic [MW-1:0]              j0, s0, sum;
  logic [MW-1:0]              count;
  logic [MW-1:0]              rem_a, rem_b;
  logic                       div_done;

  logic [KW-1:0]              key_mem [DEPTH];
  logic [1:0]                 stat_mem [DEPTH];
  logic [DEPTH-1:0]           stat_valid;
  logic [KW-1:0]              rd_key;
  logic [1:0]                 rd_stat;
  logic                       rd_valid;
  logic [1:0]                 eff_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= dhot_pkg::SLOTS_RESET;
    end else if (cfg_wr) begin
      slots_in_use <= cfg_data;
    end
  end

  always_comb begin
    if (MW'(slots_in_use) < dhot_pkg::MOD_MIN) begin
      m_next = dhot_pkg::MOD_MIN;
    end else if (MW'(slots_in_use) > DEPTH_M) begin
      m_next = DEPTH_M;
    end else begin
      m_next = MW'(slots_in_use);
    end
  end

  assign mag = key[KW-1] ? (~key + KW'(1)) : key;

  dhot_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.load),
    .dividend (mag),
    .div_a    (m_r),
    .div_b    (m_r - MW'(1)),
    .rem_a    (rem_a),
    .rem_b    (rem_b),
    .done     (div_done)
  );

  // Signed C remainders brought into range: home slot and probe step.
  always_comb begin
    j0 = (neg && rem_a != '0) ? m_r - rem_a : rem_a;
    if (!neg) begin
      s0 = rem_b + MW'(1);
    end else if (rem_b == '0) begin
      s0 = MW'(1);
    end else if (rem_b == MW'(1)) begin
      s0 = '0;  // zero step: every probe lands on the home slot
    end else begin
      s0 = m_r + MW'(1) - rem_b;
    end
  end

  always_comb begin
    sum    = MW'(j) + MW'(s);
    j_next = (sum >= m_r) ? IDX_W'(sum - m_r) : IDX_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op;
      key_r <= key;
      neg   <= key[KW-1];
      m_r   <= m_next;
    end
    if (cmd.setup) begin
      j     <= IDX_W'(j0);
      s     <= IDX_W'(s0);
      count <= '0;
    end else if (cmd.adv) begin
      j     <= j_next;
      count <= count + MW'(1);
    end
  end

  // Slot stores
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      if (op_r == dhot_pkg::OP_INSERT) begin
        key_mem[j]  <= key_r;
        stat_mem[j] <= dhot_pkg::ST_USED;
      end else begin
        key_mem[j]  <= '1;
        stat_mem[j] <= dhot_pkg::ST_GONE;
      end
    end
    if (cmd.rd) begin
      rd_key   <= key_mem[j];
      rd_stat  <= stat_mem[j];
      rd_valid <= stat_valid[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat_valid <= '0;
    end else if (cmd.wr) begin
      stat_valid[j] <= 1'b1;
    end
  end

  assign eff_stat = rd_valid ? rd_stat : dhot_pkg::ST_NEVER;

  always_comb begin
    stat.div_done = div_done;
    stat.never    = (eff_stat == dhot_pkg::ST_NEVER);
    stat.free     = (eff_stat != dhot_pkg::ST_USED);
    stat.match    = (eff_stat == dhot_pkg::ST_USED) && (rd_key == key_r);
    stat.last     = ((count + MW'(1)) == m_r);
    stat.op       = op_r;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.fin_ok | cmd.fin_fail;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_ok) begin
      slot <= SW'(j);
      ok   <= 1'b1;
    end else if (cmd.fin_fail) begin
      slot <= '0;
      ok   <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> (MW'(j) < m_r))
    else $error("probe index outside the table");
  a_fail_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (slot == '0))
    else $error("failed item carries a nonzero slot");
  a_done_follows_fin: assert property (@(posedge clk) disable iff (rst)
    (cmd.fin_ok || cmd.fin_fail) |=> done)
    else $error("finished item produced no result strobe");
`endif

endmodule

@@ rtl/double_hash_open_table.sv @@
// Top level of the double-hashing open-addressed hash table.
//
// Usage: present op and key with start high; the item is taken at a rising
// edge where start is high and busy is low. busy stays high until the item
// finishes. Each item gives one result: done is high for exactly one cycle
// with slot and ok valid; the receiver has no way to hold it off. A new
// item may be started in the same cycle that done is shown.
// op 0 inserts (first free or removed slot), 1 searches, 2 removes; any
// other op gives slot 0, ok 0. On failure slot is 0.
// cfg_wr with cfg_data sets the table size m (clamped to 2..CAPACITY); write
// it only while busy is low and no result is pending.
// Sequence: after acceptance the radix-16 remainder unit forms |key| mod m
// and |key| mod (m-1); then each of the p probes (1 to m) is a registered
// read of the slot stores followed by a check, and the result register
// raises done after the last check.
// Reset: synchronous, active high; all slots read as never used at once,
// m returns to 64 (at most CAPACITY), and no result is pending.
module double_hash_open_table #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic signed [dhot_pkg::KEY_W-1:0] key,
  input  logic                        cfg_wr,
  input  logic [dhot_pkg::CFG_W-1:0]  cfg_data,
  output logic                        done,
  output logic [dhot_pkg::SLOT_W-1:0] slot,
  output logic                        ok
);

  dhot_pkg::cmd_t  cmd;
  dhot_pkg::stat_t stat;

  dhot_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  dhot_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .op       (op),
    .key      (key),
    .cfg_wr   (cfg_wr),
    .cfg_data (cfg_data),
    .done     (done),
    .slot     (slot),
    .ok       (ok)
  );

endmodule
